### rtl/afcc_pkg.sv
// Shared constants and types of the box frustum cull compactor.
package afcc_pkg;

	localparam int NUM_PLANES  = 6;
	localparam int COORD_W     = 16;
	localparam int PLANE_W     = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int PROD_W      = 2 * COORD_W;
	localparam int ACC_W       = PROD_W + 3;
	localparam int ALIGN_SH    = 14;
	localparam int IN_DATA_W   = 6 * COORD_W;
	localparam int IDX_W       = 10;
	localparam int CNT_W       = 11;
	localparam int MAX_BOXES   = 1024;
	localparam int OUT_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// Classification of one box as it travels through the queue.
	typedef struct packed {
		logic visible;
		logic last;
	} cull_t;

	// Write side of the queue.
	typedef struct packed {
		logic  valid;
		cull_t entry;
	} qpush_t;

	// Read side of the queue.
	typedef struct packed {
		logic  valid;
		cull_t entry;
	} qhead_t;

endpackage

### rtl/afcc_front.sv
// Front part: plane registers and the two-stage six-plane positive-vertex test.
module afcc_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [afcc_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [afcc_pkg::PLANE_W-1:0]       wr_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [afcc_pkg::IN_DATA_W-1:0]     s_tdata,
	input  logic                               s_tlast,
	input  logic                               q_full,
	output afcc_pkg::qpush_t                   push
);

	logic [afcc_pkg::PLANE_W-1:0] plane_q [afcc_pkg::NUM_PLANES];

	logic signed [afcc_pkg::PROD_W-1:0] prod [afcc_pkg::NUM_PLANES][3];
	logic signed [afcc_pkg::PROD_W-1:0] prod_s1 [afcc_pkg::NUM_PLANES][3];
	logic v_s1, last_s1;
	logic v_s2, vis_s2, last_s2;
	logic adv1, adv2;
	logic vis_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < afcc_pkg::NUM_PLANES; p++) begin
				plane_q[p] <= '0;
			end
		end else if (wr_en && (wr_index < afcc_pkg::CFG_IDX_W'(afcc_pkg::NUM_PLANES))) begin
			plane_q[wr_index] <= wr_data;
		end
	end

	// Pick min or max per axis from the normal's sign bit, then multiply.
	always_comb begin
		logic signed [afcc_pkg::COORD_W-1:0] n;
		logic signed [afcc_pkg::COORD_W-1:0] c;
		for (int p = 0; p < afcc_pkg::NUM_PLANES; p++) begin
			for (int a = 0; a < 3; a++) begin
				n = plane_q[p][afcc_pkg::COORD_W*a +: afcc_pkg::COORD_W];
				c = n[afcc_pkg::COORD_W-1]
					? s_tdata[afcc_pkg::COORD_W*a +: afcc_pkg::COORD_W]
					: s_tdata[afcc_pkg::COORD_W*(a+3) +: afcc_pkg::COORD_W];
				prod[p][a] = n * c;
			end
		end
	end

	// Sum products with the aligned offset; any negative distance culls.
	always_comb begin
		logic signed [afcc_pkg::ACC_W-1:0] acc;
		logic [afcc_pkg::COORD_W-1:0] d;
		vis_d = 1'b1;
		for (int p = 0; p < afcc_pkg::NUM_PLANES; p++) begin
			d   = plane_q[p][afcc_pkg::COORD_W*3 +: afcc_pkg::COORD_W];
			acc = {{(afcc_pkg::ACC_W-afcc_pkg::COORD_W-afcc_pkg::ALIGN_SH){d[afcc_pkg::COORD_W-1]}},
				d, {afcc_pkg::ALIGN_SH{1'b0}}};
			for (int a = 0; a < 3; a++) begin
				acc = acc + {{(afcc_pkg::ACC_W-afcc_pkg::PROD_W){prod_s1[p][a][afcc_pkg::PROD_W-1]}},
					prod_s1[p][a]};
			end
			if (acc[afcc_pkg::ACC_W-1]) begin
				vis_d = 1'b0;
			end
		end
	end

	assign adv2     = !v_s2 || !q_full;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= s_tvalid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && s_tvalid) begin
			prod_s1 <= prod;
			last_s1 <= s_tlast;
		end
		if (adv2 && v_s1) begin
			vis_s2  <= vis_d;
			last_s2 <= last_s1;
		end
	end

	assign push.valid         = v_s2 && !q_full;
	assign push.entry.visible = vis_s2;
	assign push.entry.last    = last_s2;

endmodule

### rtl/afcc_queue.sv
// Short queue of classified boxes between the test and the compactor.
module afcc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  afcc_pkg::qpush_t push,
	output logic             full,
	input  logic             pop,
	output afcc_pkg::qhead_t head
);

	afcc_pkg::cull_t             mem_q [afcc_pkg::QUEUE_DEPTH];
	logic [afcc_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [afcc_pkg::QCNT_W-1:0] count_q;
	logic                        do_pop;

	assign full       = (count_q == afcc_pkg::QCNT_W'(afcc_pkg::QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push.valid && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/afcc_back.sv
// Back part: frame counters, compaction and the registered result stage.
module afcc_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  afcc_pkg::qhead_t                  head,
	output logic                              pop,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [afcc_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tuser,
	output logic                              m_tlast
);

	logic [afcc_pkg::CNT_W-1:0] box_cnt_q, vis_cnt_q;
	logic                       m_tvalid_q;
	logic [afcc_pkg::IDX_W-1:0] index_q, slot_q;
	logic [afcc_pkg::CNT_W-1:0] total_q;
	logic                       user_q, last_q;
	logic                       vis, emit;

	assign pop  = head.valid && (!m_tvalid_q || m_tready);
	assign vis  = head.entry.visible && (box_cnt_q < afcc_pkg::CNT_W'(afcc_pkg::MAX_BOXES));
	assign emit = vis || head.entry.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_cnt_q  <= '0;
			vis_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				m_tvalid_q <= emit;
				if (head.entry.last) begin
					box_cnt_q <= '0;
					vis_cnt_q <= '0;
				end else begin
					if (vis) begin
						vis_cnt_q <= vis_cnt_q + 1'b1;
					end
					if (box_cnt_q < afcc_pkg::CNT_W'(afcc_pkg::MAX_BOXES)) begin
						box_cnt_q <= box_cnt_q + 1'b1;
					end
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			index_q <= box_cnt_q[afcc_pkg::IDX_W-1:0];
			slot_q  <= vis ? vis_cnt_q[afcc_pkg::IDX_W-1:0] : '0;
			total_q <= vis_cnt_q + afcc_pkg::CNT_W'(vis);
			user_q  <= vis;
			last_q  <= head.entry.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(afcc_pkg::OUT_DATA_W-2*afcc_pkg::IDX_W-afcc_pkg::CNT_W){1'b0}},
		total_q, slot_q, index_q};
	assign m_tuser  = user_q;
	assign m_tlast  = last_q;

endmodule

### rtl/aabb_frustum_cull_compactor.sv
// Top level of the streaming box frustum cull compactor.
//
// Usage:
//   Slave channel: one axis-aligned box per item, min and max corners in Q7.8;
//   tlast marks the final box of a frame. Master channel: one item per
//   visible box, carrying its instance index, compacted slot and running
//   visible count; the final box of a frame always yields an item with tlast
//   set and the frame total, visible or not. Culled boxes that are not last
//   yield nothing.
//   Planes are written through wr_en/wr_index/wr_data (index 0 near, 5 far;
//   nx, ny, nz Q1.14 and offset Q7.8 from bit 0 up); write them only while idle.
// Timing:
//   A result reaches the master side through two test stages (multiply, then
//   sum and compare), the queue, and the output register. One item per cycle
//   is sustained while the receiver keeps up; the rate is set by the fully
//   unrolled 18-multiplier test stage.
// Reset clears the plane registers (every box then passes), both counters,
//   the queue and the output register. When the receiver stalls, the output
//   register holds its item, the four-entry queue fills, and then the test
//   stages and slave tready hold off in turn.
module aabb_frustum_cull_compactor (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [afcc_pkg::CFG_IDX_W-1:0]    wr_index,
	input  logic [afcc_pkg::PLANE_W-1:0]      wr_data,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
	input  logic [afcc_pkg::IN_DATA_W-1:0]    s_tdata,
	input  logic                              s_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// instance_index, visible_slot, visible_count, zero fill
	output logic [afcc_pkg::OUT_DATA_W-1:0]   m_tdata,
	// is_visible
	output logic                              m_tuser,
	output logic                              m_tlast
);

	afcc_pkg::qpush_t push;
	afcc_pkg::qhead_t head;
	logic             q_full;
	logic             pop;

	// Accept and classify boxes against the six planes.
	afcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (q_full),
		.push     (push)
	);

	// Decouple the test pipeline from the output side.
	afcc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	// Number, compact and emit results.
	afcc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### tb/cull_result_checker.sv
// Checker for the box frustum cull compactor: predicts each result and compares it.
`timescale 1ns / 1ps

module cull_result_checker
	import afcc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [CFG_IDX_W-1:0]    wr_index,
	input  logic [PLANE_W-1:0]      wr_data,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	input  logic [IN_DATA_W-1:0]    s_tdata,
	input  logic                    s_tlast,
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	input  logic [OUT_DATA_W-1:0]   m_tdata,
	input  logic                    m_tuser,
	input  logic                    m_tlast,
	output int                      mismatches,
	output int                      outstanding
);

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [IDX_W-1:0] slot;
		logic             visible;
		logic             done;
		logic [CNT_W-1:0] count;
	} cull_result_t;

	logic [PLANE_W-1:0] planes [NUM_PLANES];
	logic [CNT_W-1:0]   boxes_seen;
	logic [CNT_W-1:0]   visible_seen;
	cull_result_t       pending_results [$];
	int                 fails = 0;

	// Positive-vertex test against all six planes, summed exactly in 64 bits.
	function automatic logic box_passes_planes(input logic [IN_DATA_W-1:0] box);
		logic signed [COORD_W-1:0] normal;
		logic signed [COORD_W-1:0] corner;
		logic signed [COORD_W-1:0] offset;
		longint                    distance;
		for (int p = 0; p < NUM_PLANES; p++) begin
			offset   = planes[p][PLANE_W-1 -: COORD_W];
			distance = longint'(offset) * (longint'(1) << ALIGN_SH);
			for (int a = 0; a < 3; a++) begin
				normal = planes[p][COORD_W*a +: COORD_W];
				corner = normal[COORD_W-1] ? box[COORD_W*a +: COORD_W]
				                           : box[COORD_W*(a+3) +: COORD_W];
				distance += longint'(normal) * longint'(corner);
			end
			if (distance < 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cull_result_t     want;
		cull_result_t     got;
		logic [CNT_W-1:0] index;
		logic             visible;
		if (!arst_n) begin
			for (int p = 0; p < NUM_PLANES; p++)
				planes[p] = '0;
			boxes_seen   = '0;
			visible_seen = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (wr_en && wr_index < NUM_PLANES)
				planes[wr_index] = wr_data;

			if (s_tvalid && s_tready) begin
				index   = boxes_seen;
				visible = (index < MAX_BOXES) && box_passes_planes(s_tdata);
				if (visible || s_tlast) begin
					want.index   = index[IDX_W-1:0];
					want.slot    = visible ? visible_seen[IDX_W-1:0] : '0;
					want.visible = visible;
					want.done    = s_tlast;
					want.count   = visible_seen + CNT_W'(visible);
					pending_results.push_back(want);
				end
				if (s_tlast) begin
					boxes_seen   = '0;
					visible_seen = '0;
				end else begin
					if (visible)
						visible_seen = visible_seen + 1'b1;
					if (boxes_seen < MAX_BOXES)
						boxes_seen = boxes_seen + 1'b1;
				end
			end

			if (m_tvalid && m_tready) begin
				got.index   = m_tdata[IDX_W-1:0];
				got.slot    = m_tdata[2*IDX_W-1 -: IDX_W];
				got.count   = m_tdata[2*IDX_W+CNT_W-1 -: CNT_W];
				got.visible = m_tuser;
				got.done    = m_tlast;
				if (pending_results.size() == 0) begin
					$error("result with no box behind it: tdata %h tuser %b tlast %b",
						m_tdata, m_tuser, m_tlast);
					fails++;
				end else begin
					want = pending_results.pop_front();
					if (got.index !== want.index) begin
						$error("instance_index: expected %0d, actual %0d", want.index, got.index);
						fails++;
					end
					if (got.slot !== want.slot) begin
						$error("visible_slot: expected %0d, actual %0d", want.slot, got.slot);
						fails++;
					end
					if (got.visible !== want.visible) begin
						$error("is_visible: expected %0d, actual %0d", want.visible, got.visible);
						fails++;
					end
					if (got.done !== want.done) begin
						$error("frame_done: expected %0d, actual %0d", want.done, got.done);
						fails++;
					end
					if (got.count !== want.count) begin
						$error("visible_count: expected %0d, actual %0d", want.count, got.count);
						fails++;
					end
				end
			end
			outstanding <= pending_results.size();
		end
		mismatches <= fails;
	end

endmodule

### tb/tb.sv
// Top of the cull compactor testbench: clock, reset, box stimulus and verdict.
`timescale 1ns / 1ps

module tb;
	import afcc_pkg::*;

	logic                    clk      = 1'b0;
	logic                    arst_n   = 1'b0;
	logic                    wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]    wr_index = '0;
	logic [PLANE_W-1:0]      wr_data  = '0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [IN_DATA_W-1:0]    s_tdata  = '0;
	logic                    s_tlast  = 1'b0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]   m_tdata;
	logic                    m_tuser;
	logic                    m_tlast;

	int                      mismatches;
	int                      outstanding;

	// Plane set loaded by program_planes; steady_feed suppresses sender gaps.
	logic [PLANE_W-1:0]      plane_set [NUM_PLANES];
	logic                    steady_feed = 1'b0;

	localparam int LONG_FRAME = MAX_BOXES + 6;

	always #5 clk = ~clk;

	aabb_frustum_cull_compactor i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	cull_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Pack one box from the lowest bit up: min x, y, z then max x, y, z.
	function automatic logic [IN_DATA_W-1:0] pack_box(
		input logic [COORD_W-1:0] min_x, min_y, min_z,
		input logic [COORD_W-1:0] max_x, max_y, max_z);
		return {max_z, max_y, max_x, min_z, min_y, min_x};
	endfunction

	// Pack one plane: nx, ny, nz in Q1.14, then the offset in Q7.8 on top.
	function automatic logic [PLANE_W-1:0] pack_plane(
		input logic [COORD_W-1:0] nx, ny, nz, offset);
		return {offset, nz, ny, nx};
	endfunction

	// Mix full-range corners with small ones near the origin, where planes bite.
	function automatic logic [IN_DATA_W-1:0] random_box();
		logic [IN_DATA_W-1:0] box;
		for (int a = 0; a < 6; a++) begin
			if ($urandom_range(9) < 3)
				box[COORD_W*a +: COORD_W] = 16'($urandom_range(1023)) - 16'd512;
			else
				box[COORD_W*a +: COORD_W] = 16'($urandom);
		end
		return box;
	endfunction

	// Pick a plane style: off, fully random, generous offset, or one axis only.
	function automatic logic [PLANE_W-1:0] random_plane();
		logic [PLANE_W-1:0] plane;
		plane = '0;
		case ($urandom_range(3))
			0: begin
				plane = '0;
			end
			1: begin
				plane = {$urandom, $urandom};
			end
			2: begin
				plane = pack_plane(16'($urandom), 16'($urandom), 16'($urandom), 16'h7FFF);
			end
			default: begin
				plane[COORD_W*$urandom_range(2) +: COORD_W] = 16'($urandom);
				plane[PLANE_W-1 -: COORD_W] = 16'($urandom);
			end
		endcase
		return plane;
	endfunction

	// Offer one item; drop tvalid for random gaps first, then hold until taken.
	task automatic send_box(input logic [IN_DATA_W-1:0] box, input logic last);
		while (!steady_feed && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= box;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Stop offering, wait until every expected result is out, then let the
	// pipeline empty of culled boxes that leave nothing behind.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Write all six planes back to back; the block must be idle here.
	task automatic program_planes();
		wait_drained();
		for (int p = 0; p < NUM_PLANES; p++) begin
			wr_en    <= 1'b1;
			wr_index <= CFG_IDX_W'(p);
			wr_data  <= plane_set[p];
			@(posedge clk);
		end
		wr_en <= 1'b0;
	endtask

	task automatic uniform_planes(input logic [PLANE_W-1:0] plane);
		for (int p = 0; p < NUM_PLANES; p++)
			plane_set[p] = plane;
		program_planes();
	endtask

	// Well-formed frames of random length, mostly short, now and then long.
	task automatic random_frames(input int count);
		int left;
		int len;
		left = count;
		while (left > 0) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
			if (len > left)
				len = left;
			for (int i = 0; i < len; i++)
				send_box(random_box(), i == len - 1);
			left -= len;
		end
	endtask

	// Receiver: random stalls, one long hold-off while the sender keeps
	// offering (fills the output register, queue and test stages), and a
	// stretch of steady acceptance.
	initial begin
		int cycles;
		cycles = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= 100 && cycles < 220)
				m_tready <= 1'b0;
			else if (cycles >= 800 && cycles < 1300)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(99) >= 31);
		end
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Planes at reset are all zero: every distance is zero, so all pass.
		send_box(pack_box(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0);
		send_box(pack_box(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0);
		send_box(pack_box(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0);
		send_box(pack_box(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000), 1'b1);

		// Overlong frame: the box counter saturates, the tail is culled and the
		// closing item carries a wrapped index and a full visible total. Run a
		// stretch of it without gaps on the sending side.
		for (int i = 0; i < LONG_FRAME; i++) begin
			steady_feed = (i >= 400 && i < 700);
			send_box(random_box(), i == LONG_FRAME - 1);
		end
		steady_feed = 1'b0;

		// Keep boxes straddling x = 0, plus a far plane with a negative nz
		// whose magnitude has only the sign bit set.
		plane_set[0] = pack_plane(16'h4000, 16'h0000, 16'h0000, 16'h0000);
		plane_set[1] = pack_plane(16'h8000, 16'h0000, 16'h0000, 16'h0000);
		plane_set[2] = '0;
		plane_set[3] = '0;
		plane_set[4] = '0;
		plane_set[5] = pack_plane(16'h0000, 16'h0000, 16'h8000, 16'h7FFF);
		program_planes();

		send_box(pack_box(-16'sd100, 16'h0000, 16'h0000, 16'd100, 16'h0000, 16'h0000), 1'b0);
		// culled, not last: no result
		send_box(pack_box(16'd100, 16'h0000, 16'h0000, 16'd200, 16'h0000, 16'h0000), 1'b0);
		send_box(pack_box(-16'sd200, 16'h0000, 16'h0000, -16'sd100, 16'h0000, 16'h0000), 1'b0);
		// inverted in y only: still visible
		send_box(pack_box(-16'sd5, 16'd300, 16'h0000, 16'd5, -16'sd300, 16'h0000), 1'b0);
		// inverted in x: max corner negative, culled by the near plane
		send_box(pack_box(16'd50, 16'h0000, 16'h0000, -16'sd50, 16'h0000, 16'h0000), 1'b0);
		// min z beyond the far plane
		send_box(pack_box(-16'sd1, 16'h0000, 16'h7FFF, 16'd1, 16'h0000, 16'h7FFF), 1'b0);
		send_box(pack_box(-16'sd1, 16'h0000, 16'h0000, 16'd1, 16'h0000, 16'h0000), 1'b1);
		// single-box frame whose only box is culled: total of zero
		send_box(pack_box(16'd100, 16'h0000, 16'h0000, 16'd200, 16'h0000, 16'h0000), 1'b1);

		// Extreme plane words, each for a handful of frames.
		uniform_planes({PLANE_W{1'b1}});
		random_frames(10);
		uniform_planes({4{16'h8000}});
		random_frames(10);
		uniform_planes({4{16'h7FFF}});
		random_frames(10);

		// Random plane sets with well-formed frames of random boxes.
		for (int phase = 0; phase < 8; phase++) begin
			for (int p = 0; p < NUM_PLANES; p++)
				plane_set[p] = random_plane();
			program_planes();
			random_frames(100);
		end

		uniform_planes('0);
		random_frames(20);

		// Drain with a bound; anything still owed at the end is a failure.
		s_tvalid <= 1'b0;
		@(posedge clk);
		for (int n = 0; n < 5000 && outstanding != 0; n++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (outstanding != 0)
			$error("%0d expected results never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### sim.f
rtl/afcc_pkg.sv
rtl/afcc_front.sv
rtl/afcc_queue.sv
rtl/afcc_back.sv
rtl/aabb_frustum_cull_compactor.sv
tb/cull_result_checker.sv
tb/tb.sv
